>>> design/rle_pkg.sv
// Shared constants and field widths for the run-length raster expander.
// No dependencies; every other design file imports this package.
package rle_pkg;

  localparam int DATA_W        = 8;
  localparam int X_W           = 12;
  localparam int Y_W           = 16;
  localparam int LEN_W         = 7;
  localparam int COLOR_W       = 3;
  localparam int CB_W          = 3;
  localparam int HDR_W         = 7;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam int HEADER_BYTES_DEF = 64;

  localparam logic [X_W-1:0]     WIDTH_RESET = 12'd400;
  localparam logic [X_W-1:0]     WIDTH_MIN   = 12'd2;
  localparam logic [CB_W-1:0]    CB_RESET    = 3'd6;
  localparam logic [CB_W-1:0]    CB_MIN      = 3'd5;
  localparam logic [CB_W-1:0]    CB_SIX      = 3'd6;
  localparam logic [COLOR_W-1:0] COLOR_BAD   = 3'd7;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_COUNT_BITS  = 1'b1;

endpackage

>>> design/rle_in_if.sv
// Input byte channel of the run-length raster expander.
// Depends on rle_pkg for the field widths.
interface rle_in_if import rle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

>>> design/rle_out_if.sv
// Segment result channel of the run-length raster expander.
// Depends on rle_pkg for the field widths.
interface rle_out_if import rle_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [X_W-1:0]     seg_x;
  logic [Y_W-1:0]     seg_y;
  logic [LEN_W-1:0]   seg_length;
  logic [COLOR_W-1:0] color_index;
  logic               color_invalid;
  logic               run_last;

  modport source (output valid, output seg_x, output seg_y, output seg_length,
                  output color_index, output color_invalid, output run_last,
                  input ready);
  modport sink   (input valid, input seg_x, input seg_y, input seg_length,
                  input color_index, input color_invalid, input run_last,
                  output ready);
endinterface

>>> design/rle_raster_run_expander_core.sv
// Top level of the run-length raster expander: sequencer, position state,
// segment output register and APB register file. Uses rle_pkg, rle_in_if, rle_out_if.
//
// Usage: encoded image bytes arrive on in_if, one byte per transfer. A byte with
// first_byte set starts a new image and clears the raster position and header count.
// The first HEADER_BYTES bytes of an image are consumed without results. Each
// later byte splits into a run count (low count_bits bits, at least 5) and a color
// index; the run is emitted on out_if as one segment per raster row it touches.
// Throughput: a byte is accepted while idle and its segments are then loaded
// one after another; header bytes and zero counts do not leave idle. The
// single room/length subtract-and-compare unit produces one segment per cycle
// while the receiver is not stalling the output register.
// A byte's first segment is registered from the run state once the output is free.
// A stalled receiver holds the segment register; the sequencer waits on it and
// in_if.ready stays low until the current byte's last segment is loaded.
// Reset (rst_n low, synchronous) clears position, header count and the output
// valid flag and restores image_width to 400 and count_bits to 6.
module rle_raster_run_expander_core import rle_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rle_in_if.sink                in_if,
  rle_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [HDR_W-1:0] HDR_LIM = HDR_W'(HEADER_BYTES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state_r, state_nxt;
  logic [X_W-1:0]     width_r, width_nxt;
  logic [CB_W-1:0]    cb_r, cb_nxt;
  logic [HDR_W-1:0]   header_r, header_nxt;
  logic [X_W-1:0]     pos_x_r, pos_x_nxt;
  logic [Y_W-1:0]     pos_y_r, pos_y_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [X_W-1:0]     seg_x_r;
  logic [Y_W-1:0]     seg_y_r;
  logic [LEN_W-1:0]   seg_len_r;
  logic [COLOR_W-1:0] seg_color_r;
  logic               seg_last_r;

  logic [X_W-1:0]     width_eff;
  logic [CB_W-1:0]    cb_eff;
  logic               in_xfer;
  logic               cfg_wr;
  logic               load;
  logic [HDR_W-1:0]   hdr_base;
  logic [X_W-1:0]     px_base;
  logic [Y_W-1:0]     py_base;
  logic [LEN_W-1:0]   in_count;
  logic [COLOR_W-1:0] in_color;
  logic [X_W-1:0]     room;
  logic [LEN_W-1:0]   seg_len;
  logic [X_W-1:0]     pos_sum;
  logic               seg_final;

  assign width_eff = (width_r < WIDTH_MIN) ? WIDTH_MIN : width_r;
  assign cb_eff    = (cb_r < CB_MIN) ? CB_MIN : cb_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr[2] == REG_COUNT_BITS) ?
                   {{(APB_DATA_W-CB_W){1'b0}}, cb_r} :
                   {{(APB_DATA_W-X_W){1'b0}}, width_r};

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;

  always_comb begin
    unique case (cb_eff)
      CB_MIN: begin
        in_count = {2'b00, in_if.data_byte[4:0]};
        in_color = in_if.data_byte[7:5];
      end
      CB_SIX: begin
        in_count = {1'b0, in_if.data_byte[5:0]};
        in_color = {1'b0, in_if.data_byte[7:6]};
      end
      default: begin
        in_count = in_if.data_byte[6:0];
        in_color = {2'b00, in_if.data_byte[7]};
      end
    endcase
  end

  assign hdr_base = in_if.first_byte ? '0 : header_r;
  assign px_base  = in_if.first_byte ? '0 : pos_x_r;
  assign py_base  = in_if.first_byte ? '0 : pos_y_r;

  // Shared segment unit: room left in the row, clipped length, new column.
  assign room      = width_eff - pos_x_r;
  assign seg_final = ({{(X_W-LEN_W){1'b0}}, rem_r} <= room);
  assign seg_len   = seg_final ? rem_r : room[LEN_W-1:0];
  assign pos_sum   = pos_x_r + {{(X_W-LEN_W){1'b0}}, seg_len};
  assign load      = (state_r == ST_RUN) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt  = state_r;
    header_nxt = header_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    rem_nxt    = rem_r;
    color_nxt  = color_r;
    width_nxt  = width_r;
    cb_nxt     = cb_r;

    if (cfg_wr) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        width_nxt = pwdata[X_W-1:0];
      end else begin
        cb_nxt = pwdata[CB_W-1:0];
      end
    end

    if (in_xfer) begin
      header_nxt = hdr_base;
      pos_x_nxt  = px_base;
      pos_y_nxt  = py_base;
      if (hdr_base < HDR_LIM) begin
        header_nxt = hdr_base + 1'b1;
      end else if (in_count != '0) begin
        rem_nxt   = in_count;
        color_nxt = in_color;
        state_nxt = ST_RUN;
        if (px_base >= width_eff) begin
          pos_x_nxt = '0;
          pos_y_nxt = py_base + 1'b1;
        end
      end
    end

    if (load) begin
      rem_nxt = rem_r - seg_len;
      if (pos_sum == width_eff) begin
        pos_x_nxt = '0;
        pos_y_nxt = pos_y_r + 1'b1;
      end else begin
        pos_x_nxt = pos_sum;
      end
      if (seg_final) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WIDTH_RESET;
      cb_r        <= CB_RESET;
      header_r    <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      cb_r        <= cb_nxt;
      header_r    <= header_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    color_r <= color_nxt;
    if (load) begin
      seg_x_r     <= pos_x_r;
      seg_y_r     <= pos_y_r;
      seg_len_r   <= seg_len;
      seg_color_r <= color_r;
      seg_last_r  <= seg_final;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.seg_x         = seg_x_r;
  assign out_if.seg_y         = seg_y_r;
  assign out_if.seg_length    = seg_len_r;
  assign out_if.color_index   = seg_color_r;
  assign out_if.color_invalid = (seg_color_r >= COLOR_BAD);
  assign out_if.run_last      = seg_last_r;

`ifndef SYNTH
  a_run_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (rem_r != '0))
    else $error("Run state entered with no pixels left.");

  a_seg_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (seg_len_r != '0))
    else $error("Empty segment presented on the output.");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (load && seg_final) |=> (state_r == ST_IDLE) && (rem_r == '0))
    else $error("Final segment did not return the sequencer to idle.");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for rle_raster_run_expander_core: drives image bytes, register
// writes and output stalls, predicts every row segment and compares transfers in order.
// Depends on rle_pkg, rle_in_if and rle_out_if from the design folder.
`timescale 1ns / 100ps

module testbench;
  import rle_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_SEGS    = 64;
  localparam int SETTLE      = 8;
  localparam int PRINT_MAX   = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [X_W-1:0]     seg_x;
    logic [Y_W-1:0]     seg_y;
    logic [LEN_W-1:0]   seg_length;
    logic [COLOR_W-1:0] color_index;
    logic               color_invalid;
    logic               run_last;
  } seg_t;

  class run_scoreboard;
    logic [X_W-1:0]   width_reg;
    logic [CB_W-1:0]  cbits_reg;
    logic [HDR_W-1:0] hdr_count;
    logic [X_W-1:0]   pos_x;
    logic [Y_W-1:0]   pos_y;
    seg_t             expected_segs[$];
    int               errors;
    int               bytes_in;
    int               run_bytes;
    int               segs_checked;
    int               row_wraps;
    int               reg_writes;

    function new();
      width_reg = WIDTH_RESET;
      cbits_reg = CB_RESET;
      hdr_count = '0;
      pos_x     = '0;
      pos_y     = '0;
    endfunction

    task report(input string msg);
      if (errors < PRINT_MAX) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function string seg_text(input seg_t s);
      return $sformatf("x=%0d y=%0d len=%0d c=%0d inv=%0b last=%0b", s.seg_x, s.seg_y,
                       s.seg_length, s.color_index, s.color_invalid, s.run_last);
    endfunction

    function void write_reg(input logic sel, input logic [APB_DATA_W-1:0] value);
      reg_writes++;
      if (sel == REG_IMAGE_WIDTH) width_reg = value[X_W-1:0];
      else cbits_reg = value[CB_W-1:0];
    endfunction

    function void next_row();
      pos_x = '0;
      pos_y = pos_y + 1'b1;
      if (pos_y == '0) row_wraps++;
    endfunction

    function void predict_byte(input logic [DATA_W-1:0] b, input logic first);
      logic [X_W-1:0]     wid;
      logic [CB_W-1:0]    cb;
      logic [COLOR_W-1:0] color;
      int unsigned        left;
      int unsigned        room;
      int unsigned        len;
      int                 n;
      seg_t               s;
      bytes_in++;
      wid = (width_reg < WIDTH_MIN) ? WIDTH_MIN : width_reg;
      cb  = (cbits_reg < CB_MIN) ? CB_MIN : cbits_reg;
      if (first) begin
        hdr_count = '0;
        pos_x     = '0;
        pos_y     = '0;
      end
      if (hdr_count < HEADER_BYTES_DEF) begin
        hdr_count++;
        return;
      end
      run_bytes++;
      left  = b & ((32'd1 << cb) - 1);
      color = COLOR_W'(b >> cb);
      if (left != 0 && pos_x >= wid) next_row();
      n = 0;
      while (left != 0 && n < MAX_SEGS) begin
        room            = wid - pos_x;
        len             = (left < room) ? left : room;
        s.seg_x         = pos_x;
        s.seg_y         = pos_y;
        s.seg_length    = LEN_W'(len);
        s.color_index   = color;
        s.color_invalid = (color >= COLOR_BAD);
        s.run_last      = (len == left);
        expected_segs.push_back(s);
        n++;
        left  -= len;
        pos_x += X_W'(len);
        if (pos_x == wid) next_row();
      end
    endfunction

    task check_segment(input seg_t got);
      seg_t  exp_seg;
      string bad;
      if (expected_segs.size() == 0) begin
        report({"unexpected segment ", seg_text(got)});
        return;
      end
      exp_seg = expected_segs.pop_front();
      segs_checked++;
      bad = "";
      if (got.seg_x != exp_seg.seg_x) bad = {bad, " seg_x"};
      if (got.seg_y != exp_seg.seg_y) bad = {bad, " seg_y"};
      if (got.seg_length != exp_seg.seg_length) bad = {bad, " seg_length"};
      if (got.color_index != exp_seg.color_index) bad = {bad, " color_index"};
      if (got.color_invalid != exp_seg.color_invalid) bad = {bad, " color_invalid"};
      if (got.run_last != exp_seg.run_last) bad = {bad, " run_last"};
      if (bad != "")
        report($sformatf("wrong%s: got %s, exp %s", bad, seg_text(got),
                         seg_text(exp_seg)));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rle_in_if  in_bus();
  rle_out_if out_bus();

  run_scoreboard sb = new();
  int            cycles;
  bit            hold_request;
  bit            in_idle;
  bit            out_idle;

  rle_raster_run_expander_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d segments pending.", cycles,
               sb.expected_segs.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      sb.predict_byte(in_bus.data_byte, in_bus.first_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_segment('{out_bus.seg_x, out_bus.seg_y, out_bus.seg_length,
                         out_bus.color_index, out_bus.color_invalid, out_bus.run_last});
  end

  initial begin
    int ready_gap;
    int hold_left;
    bit hold_taken;
    ready_gap     = 0;
    hold_left     = 0;
    hold_taken    = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (ready_gap > 0) begin
        out_bus.ready <= 1'b0;
        ready_gap--;
      end else begin
        out_bus.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) ready_gap = out_idle ? $urandom_range(0, 8) : 0;
    end
  end

  task automatic apb_write(input logic sel, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(sel, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_IMAGE_WIDTH && rd[X_W-1:0] != sb.width_reg)
      sb.report($sformatf("image_width reads %0d, written %0d", rd[X_W-1:0], sb.width_reg));
    if (sel == REG_COUNT_BITS && rd[CB_W-1:0] != sb.cbits_reg)
      sb.report($sformatf("count_bits reads %0d, written %0d", rd[CB_W-1:0], sb.cbits_reg));
  endtask

  task automatic set_config(input int wid, input int cb);
    apb_write(REG_IMAGE_WIDTH, {$urandom} << X_W | APB_DATA_W'(wid));
    apb_write(REG_COUNT_BITS, {$urandom} << CB_W | APB_DATA_W'(cb));
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic first);
    int gap;
    gap = in_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    repeat (gap) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.first_byte <= first;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_header();
    send_byte(DATA_W'($urandom), 1'b1);
    repeat (HEADER_BYTES_DEF - 1) send_byte(DATA_W'($urandom), 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.expected_segs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.first_byte = 1'b0;
    in_idle           = 1'b1;
    out_idle          = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset the header count starts at zero even without a first-byte marker.
    repeat (HEADER_BYTES_DEF) send_byte(DATA_W'($urandom), 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    drain();

    // Width and count size below their floors; the column is already past the new width.
    set_config(1, 3);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h21, 1'b0);
    drain();

    set_config(4095, 7);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    drain();

    set_config(0, 0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFE, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       set_config(2, 5);
        1:       set_config(4095, 7);
        2:       set_config($urandom_range(2, 16), $urandom_range(0, 7));
        3:       set_config($urandom_range(2, 4095), $urandom_range(0, 7));
        4:       set_config(3, 5);
        5:       set_config($urandom_range(17, 200), $urandom_range(0, 7));
        6:       set_config(1, $urandom_range(0, 7));
        default: set_config($urandom_range(2, 64), $urandom_range(0, 7));
      endcase
      in_idle  = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      // A marker restarts the image in the middle of the run data.
      if (p == 4) send_header();
      repeat (8) send_byte(DATA_W'($urandom), 1'b0);
      drain();
    end

    // Receiver holds off for a long stretch while long runs keep arriving.
    set_config(3, 7);
    in_idle      = 1'b0;
    out_idle     = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_byte({1'($urandom), 1'b1, 6'($urandom)}, 1'b0);
    drain();

    $display("Run covered %0d input bytes (%0d run bytes) and %0d checked segments.",
             sb.bytes_in, sb.run_bytes, sb.segs_checked);
    $display("Register writes: %0d; row counter wraps: %0d; mismatches: %0d.",
             sb.reg_writes, sb.row_wraps, sb.errors);
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
design/rle_pkg.sv
design/rle_in_if.sv
design/rle_out_if.sv
design/rle_raster_run_expander_core.sv
tb/sv/testbench.sv
